// File: rtl/core/rkc_pkg.sv
// ----------------------------------------------------------------------------
// rkc_pkg: shared types and constants of the 3x3 RGB convolution filter
// Item payloads, configuration indexes, reset values and coefficient access.
// ----------------------------------------------------------------------------
package rkc_pkg;

  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 16;
  localparam int KROW_W    = 48;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = 24;
  localparam int AREA_W    = IMG_W_W + IMG_H_W;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MIN_SIZE       = 3;
  localparam int PIPE_LAT       = 5;
  localparam int OUT_FIFO_DEPTH = 8;

  localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = 16'd480;
  localparam logic [KROW_W-1:0]  KTOP_RST   = 48'd0;
  localparam logic [KROW_W-1:0]  KMID_RST   = 48'd256;
  localparam logic [KROW_W-1:0]  KBOT_RST   = 48'd0;
  localparam logic [7:0]         PIX_MAX    = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_KERNEL_TOP   = 3'd2,
    CFG_KERNEL_MID   = 3'd3,
    CFG_KERNEL_BOT   = 3'd4
  } rkc_cfg_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } rkc_req_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } rkc_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } rkc_out_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } rkc_ctrl_t;

  typedef logic [2:0][2:0][PIX_W-1:0] rkc_win_t;
  typedef logic [2:0][KROW_W-1:0]     rkc_kernel_t;

  function automatic logic signed [15:0] rkc_coef(input logic [KROW_W-1:0] krow,
                                                  input logic [1:0] col);
    logic [15:0] bits;
    case (col)
      2'd0:    bits = krow[15:0];
      2'd1:    bits = krow[31:16];
      2'd2:    bits = krow[47:32];
      default: bits = 16'd0;
    endcase
    return $signed(bits);
  endfunction

endpackage

// File: rtl/core/rkc_window.sv
// ----------------------------------------------------------------------------
// rkc_window: line stores and 3x3 pixel window
// Reads both line stores at the item's column, rotates the column and writes
// it back in the following cycle, forwarding when the next item hits the same entry.
// ----------------------------------------------------------------------------
module rkc_window import rkc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [PIX_W-1:0] px_i,
  input  rkc_ctrl_t        ctrl_i,
  output logic             valid_o,
  output rkc_ctrl_t        ctrl_o,
  output rkc_win_t         win_o
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
  logic [PIX_W-1:0] upper_rd_q, lower_rd_q;

  logic             s1_valid_q;
  logic [AW-1:0]    s1_addr_q;
  logic [PIX_W-1:0] s1_px_q;
  rkc_ctrl_t        s1_ctrl_q;

  logic             fwd_q;
  logic [PIX_W-1:0] fwd_upper_q, fwd_lower_q;
  logic [PIX_W-1:0] upper_eff, lower_eff;

  rkc_win_t  win_q, win_d;
  logic      win_valid_q;
  rkc_ctrl_t win_ctrl_q;

  assign upper_eff = fwd_q ? fwd_upper_q : upper_rd_q;
  assign lower_eff = fwd_q ? fwd_lower_q : lower_rd_q;

  always_ff @(posedge clk_i) begin
    upper_rd_q <= upper_mem[addr_i];
    if (s1_valid_q) begin
      upper_mem[s1_addr_q] <= lower_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    lower_rd_q <= lower_mem[addr_i];
    if (s1_valid_q) begin
      lower_mem[s1_addr_q] <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q   <= addr_i;
    s1_px_q     <= px_i;
    s1_ctrl_q   <= ctrl_i;
    fwd_upper_q <= lower_eff;
    fwd_lower_q <= s1_px_q;
    win_ctrl_q  <= s1_ctrl_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      win_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= take_i;
      fwd_q       <= s1_valid_q && (s1_addr_q == addr_i);
      win_valid_q <= s1_valid_q;
    end
  end

  always_comb begin
    win_d = win_q;
    if (s1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r][0] = win_q[r][1];
        win_d[r][1] = win_q[r][2];
      end
      win_d[0][2] = upper_eff;
      win_d[1][2] = lower_eff;
      win_d[2][2] = s1_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  assign valid_o = win_valid_q;
  assign ctrl_o  = win_ctrl_q;
  assign win_o   = win_q;

endmodule

// File: rtl/core/rkc_filter.sv
// ----------------------------------------------------------------------------
// rkc_filter: per-channel 3x3 multiply-accumulate with clamping
// Products, row sums and the final sum with clamp each take one stage.
// ----------------------------------------------------------------------------
module rkc_filter import rkc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  rkc_ctrl_t   ctrl_i,
  input  rkc_win_t    win_i,
  input  rkc_kernel_t kernel_i,
  output logic        valid_o,
  output rkc_out_t    data_o
);

  localparam int PROD_W = 25;
  localparam int SUM_W  = 28;

  logic signed [PROD_W-1:0] prod_d [3][3][3];
  logic signed [PROD_W-1:0] f1_prod_q [3][3][3];
  logic signed [SUM_W-1:0]  rs_d [3][3];
  logic signed [SUM_W-1:0]  f2_rs_q [3][3];
  logic signed [SUM_W-1:0]  total [3];
  logic [7:0]               chan [3];

  logic             f1_valid_q, f2_valid_q, f3_valid_q;
  rkc_ctrl_t        f1_ctrl_q, f2_ctrl_q;
  logic [PIX_W-1:0] f1_center_q, f2_center_q;
  rkc_out_t         f3_data_q;

  function automatic logic [7:0] clamp_sum(input logic signed [SUM_W-1:0] s);
    if (s < 0) begin
      return 8'd0;
    end else if (|s[SUM_W-1:16]) begin
      return PIX_MAX;
    end else begin
      return s[15:8];
    end
  endfunction

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          prod_d[ch][a][b] = $signed({17'd0, win_i[a][b][8*(2-ch) +: 8]}) *
                             PROD_W'(rkc_coef(kernel_i[2-a], 2'(2-b)));
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int a = 0; a < 3; a++) begin
        rs_d[ch][a] = SUM_W'(f1_prod_q[ch][a][0]) + SUM_W'(f1_prod_q[ch][a][1]) +
                      SUM_W'(f1_prod_q[ch][a][2]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      total[ch] = f2_rs_q[ch][0] + f2_rs_q[ch][1] + f2_rs_q[ch][2];
      chan[ch]  = f2_ctrl_q.interior ? clamp_sum(total[ch])
                                     : f2_center_q[8*(2-ch) +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    f1_prod_q              <= prod_d;
    f1_ctrl_q              <= ctrl_i;
    f1_center_q            <= win_i[1][1];
    f2_rs_q                <= rs_d;
    f2_ctrl_q              <= f1_ctrl_q;
    f2_center_q            <= f1_center_q;
    f3_data_q.red_out      <= chan[0];
    f3_data_q.green_out    <= chan[1];
    f3_data_q.blue_out     <= chan[2];
    f3_data_q.frame_last   <= f2_ctrl_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= valid_i;
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
    end
  end

  assign valid_o = f3_valid_q;
  assign data_o  = f3_data_q;

endmodule

// File: rtl/core/rgb_kernel_convolution_3x3.sv
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_3x3: 3x3 RGB convolution on a raster pixel stream
// A result leaves the five-stage pipeline into an eight-entry output queue.
// Throughput is one item per cycle while in_ready_o is high (fewer than eight
// results queued or in flight), set by the single read/write-back pass
// through the two line-store memories. Reset clears counters and window and
// restores the default configuration; line stores are not cleared.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution_3x3 import rkc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rkc_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rkc_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW    = ((AW > IMG_W_W) ? AW : IMG_W_W) + 1;
  localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1) + 1;

  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;
  rkc_kernel_t        kernel_q;

  logic [AW-1:0]      col_q, col_d;
  logic [IMG_H_W-1:0] row_q, row_d;
  logic [AREA_W-1:0]  em_q, em_d, em_inc, area;
  logic [IMG_W_W-1:0] w_use;
  logic [IMG_H_W-1:0] h_use;
  logic [CW-1:0]      col_ext, w_ext;

  logic             accept, flush, take, wrap;
  logic [PIX_W-1:0] px;
  rkc_ctrl_t        ctrl;

  logic [PIPE_LAT-1:0] pend_q;
  logic [CNT_W-1:0]    busy;

  logic        win_valid;
  rkc_ctrl_t   win_ctrl;
  rkc_win_t    win;
  logic        filt_valid;
  rkc_out_t    filt_data;

  rkc_out_t         fifo_q [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      kernel_q <= {KBOT_RST, KMID_RST, KTOP_RST};
    end else if (cfg_we_i) begin
      case (rkc_cfg_e'(cfg_addr_i))
        CFG_IMAGE_WIDTH:  width_q     <= cfg_wdata_i[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: height_q    <= cfg_wdata_i[IMG_H_W-1:0];
        CFG_KERNEL_TOP:   kernel_q[0] <= cfg_wdata_i[KROW_W-1:0];
        CFG_KERNEL_MID:   kernel_q[1] <= cfg_wdata_i[KROW_W-1:0];
        CFG_KERNEL_BOT:   kernel_q[2] <= cfg_wdata_i[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < IMG_W_W'(MIN_SIZE)) begin
      w_use = IMG_W_W'(MIN_SIZE);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_use = IMG_W_W'(MAX_WIDTH);
    end else begin
      w_use = width_q;
    end
    h_use = (height_q < IMG_H_W'(MIN_SIZE)) ? IMG_H_W'(MIN_SIZE) : height_q;
  end

  assign area    = AREA_W'(w_use) * AREA_W'(h_use);
  assign col_ext = CW'(col_q);
  assign w_ext   = CW'(w_use);

  assign accept = in_valid_i && in_ready_o;
  assign flush  = (in_data_i.req_type == REQ_FLUSH);
  assign take   = accept && (flush ? (row_q >= h_use) : (row_q < h_use));
  assign px     = flush ? '0 : {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
  assign wrap   = (col_ext + CW'(1)) >= w_ext;
  assign em_inc = em_q + AREA_W'(1);

  always_comb begin
    ctrl.emit     = (row_q >= IMG_H_W'(2)) || (row_q == IMG_H_W'(1) && col_ext >= CW'(1));
    ctrl.interior = (row_q >= IMG_H_W'(2)) && (row_q <= h_use - IMG_H_W'(1)) &&
                    (col_ext >= CW'(2)) && (col_ext <= w_ext - CW'(1));
    ctrl.last     = 1'b0;
    col_d         = wrap ? '0 : AW'(col_ext + CW'(1));
    row_d         = (wrap && row_q < h_use) ? row_q + IMG_H_W'(1) : row_q;
    em_d          = em_q;
    if (ctrl.emit) begin
      em_d = em_inc;
      if (em_inc >= area) begin
        ctrl.last = 1'b1;
        col_d     = '0;
        row_d     = '0;
        em_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      em_q  <= '0;
    end else if (take) begin
      col_q <= col_d;
      row_q <= row_d;
      em_q  <= em_d;
    end
  end

  rkc_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .addr_i  (col_q),
    .px_i    (px),
    .ctrl_i  (ctrl),
    .valid_o (win_valid),
    .ctrl_o  (win_ctrl),
    .win_o   (win)
  );

  rkc_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (win_valid && win_ctrl.emit),
    .ctrl_i   (win_ctrl),
    .win_i    (win),
    .kernel_i (kernel_q),
    .valid_o  (filt_valid),
    .data_o   (filt_data)
  );

  always_comb begin
    busy = cnt_q;
    for (int i = 0; i < PIPE_LAT; i++) begin
      busy = busy + CNT_W'(pend_q[i]);
    end
  end

  assign in_ready_o = busy < CNT_W'(OUT_FIFO_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= {pend_q[PIPE_LAT-2:0], take && ctrl.emit};
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (filt_valid) begin
      fifo_q[wr_ptr_q] <= filt_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (filt_valid) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(filt_valid) - CNT_W'(pop);
    end
  end

endmodule
